@@ src/sbh_pkg.sv @@
// Shared types and constants of the SHA-256 byte stream hasher.
package sbh_pkg;

	// One request: a message byte, or none, and the end-of-message mark.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       msg_last;
	} req_t;

	// One digest word on the result channel.
	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} digest_t;

	// Eight 32-bit words, index 0 is the most significant word.
	typedef logic [0:7][31:0] hash_t;

	// Control from the byte sequencer to the compression unit.
	typedef struct packed {
		logic push;   // shift one packed word into the schedule
		logic start;  // begin 64 rounds on the current block
		logic init;   // reload the initial hash value
	} core_ctrl_t;

	// Status from the compression unit.
	typedef struct packed {
		logic busy;
	} core_sts_t;

	typedef enum logic [2:0] {
		ST_ACCEPT,
		ST_MARK,
		ST_PAD,
		ST_FINAL,
		ST_OUT
	} state_t;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;

	localparam hash_t IV_HASH = {
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
		32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
		32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
		32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
		32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
		32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
		32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
		32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
		32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
		32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
		32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
		32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
		32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
		32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
		32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
		32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
	};

endpackage

@@ src/sbh_stream_if.sv @@
// Valid/ready stream channel carrying one payload per handshake.
interface sbh_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ src/sbh_core.sv @@
// SHA-256 compression unit: schedule shift line, one shared round, hash words.
module sbh_core (
	input  logic               clk,
	input  logic               arst_n,
	input  sbh_pkg::core_ctrl_t ctrl,
	input  logic [31:0]        word,
	output sbh_pkg::core_sts_t  sts,
	output sbh_pkg::hash_t      hash
);
	import sbh_pkg::*;

	function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned s);
		return (x >> s) | (x << (32 - s));
	endfunction

	hash_t             hash_q;
	hash_t             vars_q;
	logic [0:15][31:0] w_q;
	logic [5:0]        rnd_q;
	logic              active_q;
	logic              fold_q;

	logic [31:0] s0_w;
	logic [31:0] s1_w;
	logic [31:0] w_next;
	logic [31:0] big_s1;
	logic [31:0] big_s0;
	logic [31:0] ch;
	logic [31:0] maj;
	logic [31:0] t1;
	logic [31:0] t2;

	// Schedule: w_q[0] is the word of this round, the next word enters at the end.
	assign s0_w   = ror(w_q[1], 7) ^ ror(w_q[1], 18) ^ (w_q[1] >> 3);
	assign s1_w   = ror(w_q[14], 17) ^ ror(w_q[14], 19) ^ (w_q[14] >> 10);
	assign w_next = w_q[0] + s0_w + w_q[9] + s1_w;

	assign big_s1 = ror(vars_q[4], 6) ^ ror(vars_q[4], 11) ^ ror(vars_q[4], 25);
	assign big_s0 = ror(vars_q[0], 2) ^ ror(vars_q[0], 13) ^ ror(vars_q[0], 22);
	assign ch     = (vars_q[4] & vars_q[5]) ^ (~vars_q[4] & vars_q[6]);
	assign maj    = (vars_q[0] & vars_q[1]) ^ (vars_q[0] & vars_q[2]) ^
	                (vars_q[1] & vars_q[2]);
	assign t1     = vars_q[7] + big_s1 + ch + ROUND_K[rnd_q] + w_q[0];
	assign t2     = big_s0 + maj;

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			w_q <= {w_q[1:15], word};
		end else if (active_q) begin
			w_q <= {w_q[1:15], w_next};
		end
		if (ctrl.start) begin
			vars_q <= hash_q;
		end else if (active_q) begin
			vars_q <= {t1 + t2, vars_q[0], vars_q[1], vars_q[2],
			           vars_q[3] + t1, vars_q[4], vars_q[5], vars_q[6]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q   <= IV_HASH;
			rnd_q    <= '0;
			active_q <= 1'b0;
			fold_q   <= 1'b0;
		end else begin
			fold_q <= 1'b0;
			if (ctrl.start) begin
				rnd_q    <= '0;
				active_q <= 1'b1;
			end else if (active_q) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'd63) begin
					active_q <= 1'b0;
					fold_q   <= 1'b1;
				end
			end
			if (ctrl.init) begin
				hash_q <= IV_HASH;
			end else if (fold_q) begin
				for (int i = 0; i < 8; i++) begin
					hash_q[i] <= hash_q[i] + vars_q[i];
				end
			end
		end
	end

	assign sts.busy = active_q | fold_q;
	assign hash     = hash_q;

endmodule

@@ src/sha256_byte_stream_hasher.sv @@
// SHA-256 over a byte stream: byte packing, padding, compression and digest output.
//
// Each request carries one message byte or none, plus an end-of-message mark.
// Bytes are taken one per cycle while the compression unit is idle and packed
// big-endian into 32-bit schedule words. When the 64th byte of a block arrives,
// the compression unit runs 64 rounds on one shared round datapath and then
// folds the result into the hash words; no request is taken until it is done.
// On the end mark the block appends 0x80, zero bytes and the 64-bit bit
// length (byte count modulo 2^61, times eight), one pad byte per cycle while
// the compression unit is idle, using one or two further compressions. It then
// offers the eight digest words, most significant first, on the result
// channel, with last_word set on the eighth, and starts over with the initial
// hash for the next message. A request with neither a byte nor the end mark
// changes nothing.
module sha256_byte_stream_hasher (
	input  logic         clk,
	input  logic         arst_n,
	sbh_stream_if.sink   req_in,
	sbh_stream_if.source digest_out
);
	import sbh_pkg::*;

	state_t      state_q;
	state_t      state_d;
	logic [5:0]  pos_q;       // byte position within the current block
	logic [23:0] acc_q;       // bytes of the word being packed
	logic [60:0] byte_cnt_q;  // message length in bytes
	logic        spill_q;     // pad mark landed too late for the length field
	logic [2:0]  out_idx_q;

	core_ctrl_t  core_ctrl;
	core_sts_t   core_sts;
	hash_t       hash;

	logic        byte_push;
	logic        msg_byte;
	logic [7:0]  byte_val;
	logic        len_phase;
	logic [63:0] len_bits;
	logic [7:0]  len_byte;
	logic        out_take;

	assign len_bits  = {byte_cnt_q, 3'b000};
	assign len_byte  = len_bits[{3'd7 - pos_q[2:0], 3'b000} +: 8];
	assign len_phase = !spill_q && (pos_q >= LEN_POS);
	assign out_take  = digest_out.valid && digest_out.ready;

	// Sequencer: take bytes, then generate pad bytes, then hand out the digest.
	always_comb begin
		state_d         = state_q;
		byte_push       = 1'b0;
		msg_byte        = 1'b0;
		byte_val        = req_in.payload.data_byte;
		req_in.ready    = 1'b0;
		digest_out.valid = 1'b0;
		core_ctrl.init  = 1'b0;
		unique case (state_q)
			ST_ACCEPT: begin
				req_in.ready = !core_sts.busy;
				if (req_in.valid && !core_sts.busy) begin
					byte_push = req_in.payload.byte_valid;
					msg_byte  = req_in.payload.byte_valid;
					if (req_in.payload.msg_last) begin
						state_d = ST_MARK;
					end
				end
			end
			ST_MARK: begin
				if (!core_sts.busy) begin
					byte_push = 1'b1;
					byte_val  = PAD_MARK;
					state_d   = ST_PAD;
				end
			end
			ST_PAD: begin
				if (!core_sts.busy) begin
					byte_push = 1'b1;
					byte_val  = len_phase ? len_byte : 8'h00;
					if (len_phase && pos_q == 6'd63) begin
						state_d = ST_FINAL;
					end
				end
			end
			ST_FINAL: begin
				if (!core_sts.busy) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				digest_out.valid = 1'b1;
				if (digest_out.ready && out_idx_q == 3'd7) begin
					core_ctrl.init = 1'b1;
					state_d        = ST_ACCEPT;
				end
			end
			default: begin
				state_d = ST_ACCEPT;
			end
		endcase
		// A full word goes to the schedule; a full block starts the rounds.
		core_ctrl.push  = byte_push && (pos_q[1:0] == 2'b11);
		core_ctrl.start = byte_push && (pos_q == 6'd63);
	end

	assign digest_out.payload.digest_word = hash[out_idx_q];
	assign digest_out.payload.word_index  = out_idx_q;
	assign digest_out.payload.last_word   = (out_idx_q == 3'd7);

	always_ff @(posedge clk) begin
		if (byte_push) begin
			acc_q <= {acc_q[15:0], byte_val};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_ACCEPT;
			pos_q      <= '0;
			byte_cnt_q <= '0;
			spill_q    <= 1'b0;
			out_idx_q  <= '0;
		end else begin
			state_q <= state_d;
			if (byte_push) begin
				pos_q <= pos_q + 6'd1;
			end
			if (msg_byte) begin
				byte_cnt_q <= byte_cnt_q + 61'd1;
			end else if (core_ctrl.init) begin
				byte_cnt_q <= '0;
			end
			// Hold the length back one block when the mark lands in the last eight bytes.
			if (byte_push && pos_q == 6'd63) begin
				spill_q <= 1'b0;
			end else if (byte_push && state_q == ST_MARK && pos_q >= LEN_POS) begin
				spill_q <= 1'b1;
			end
			if (out_take) begin
				out_idx_q <= out_idx_q + 3'd1;
			end
		end
	end

	sbh_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (core_ctrl),
		.word   ({acc_q, byte_val}),
		.sts    (core_sts),
		.hash   (hash)
	);

`ifndef NO_ASSERTIONS
	// Drop no request into a block that is still being compressed.
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_in.ready |-> !core_sts.busy)
		else $error("request taken while compression runs");

	// Offer digest words only after the final fold has finished.
	a_out_after_fold: assert property (@(posedge clk) disable iff (!arst_n)
		digest_out.valid |-> !core_sts.busy)
		else $error("digest offered while compression runs");

	// A block starts only together with its sixteenth schedule word.
	a_start_full: assert property (@(posedge clk) disable iff (!arst_n)
		core_ctrl.start |-> core_ctrl.push)
		else $error("compression started on a partial word");

	// After the eighth word the next message starts from a clean count.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(out_take && out_idx_q == 3'd7) |=>
		(byte_cnt_q == 61'd0 && pos_q == 6'd0 && state_q == ST_ACCEPT))
		else $error("state not cleared after digest");
`endif

endmodule
